FILE: hdl/tcs_pkg.sv
// Shared types and constants for the texture column scaler.
`timescale 1ns / 1ps

package tcs_pkg;

    // Default number of logical screen rows.
    localparam int VIEW_ROWS_DEF = 50;

    // Field widths fixed by the slice format.
    localparam int COLUMN_W = 8;
    localparam int TEX_W    = 16;
    localparam int DIST_W   = 16;
    localparam int PAIR_W   = 7;
    localparam int ROW_W    = 6;

    // Scaled distance is bits [15:6] of the 16-bit product.
    localparam int SCALED_LSB = 6;
    localparam int SCALED_W   = DIST_W - SCALED_LSB;

    // Height = 65535 / (24 * scaled); the quotient never exceeds 2730.
    localparam int H_W        = 12;
    localparam int DIVISOR_W  = 15;
    localparam int DIV_STEPS  = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam logic [H_W-1:0] HEIGHT_AT_ZERO = 12'd2730;

    // Texture walk: one-hot pointer and 16/height accumulator.
    localparam logic [TEX_W-1:0] TEX_TOP = 16'h8000;
    localparam int ACC_W      = 15;
    localparam logic [ACC_W-1:0] TEX_STEP = 15'd16;

    // Clipped slices skip ahead by up to seven texels in three steps.
    localparam int SKIP_STEPS = 3;
    localparam int SKIP_K_W   = 2;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_SKIP,
        ST_EMIT,
        ST_STEP
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic setup;
        logic skip_step;
        logic row_adv;
        logic sub;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
        logic h_zero;
        logic clip;
        logic skip_last;
        logic last_row;
        logic acc_ge_h;
    } t_dp_status;

endpackage

FILE: hdl/texture_column_scaler_core.sv
// Top level of the texture column scaler: controller plus datapath.
`timescale 1ns / 1ps
//
// Usage: one request on the input channel describes one wall slice (column,
// light and dark texture columns, distance and correction factor). The block
// answers with one row result per visible screen row, top to bottom, with
// o_last high on the final row of the slice. Both channels use valid/ready.
// A request is accepted only while the block is idle; the next one is taken
// in the cycle after the last row of the previous slice is delivered.
// The first row is offered once the request has passed through the bit-serial
// divider for the height and the setup state; a slice taller than the screen
// also passes through the skip state, which skips texels.
// Before every further row the step state moves the texel pointer down one
// texel per cycle, and the next row is offered only once the walk is done.
// When the receiver stalls, the current row is held unchanged until taken.
// Reset (synchronous, active low) returns the controller to idle and drops
// any slice in progress; the datapath registers need no reset.
//

module texture_column_scaler_core #(
    parameter int VIEW_ROWS = tcs_pkg::VIEW_ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [tcs_pkg::COLUMN_W-1:0]  i_column,
    input  logic [tcs_pkg::TEX_W-1:0]     i_light_bits,
    input  logic [tcs_pkg::TEX_W-1:0]     i_dark_bits,
    input  logic [tcs_pkg::DIST_W-1:0]    i_distance,
    input  logic [tcs_pkg::DIST_W-1:0]    i_dist_scale,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tcs_pkg::PAIR_W-1:0]    o_pixel_pair,
    output logic [tcs_pkg::ROW_W-1:0]     o_row,
    output logic                          o_light_pixel,
    output logic                          o_dark_pixel,
    output logic                          o_last
);

    tcs_pkg::t_dp_cmd    dp_cmd;
    tcs_pkg::t_dp_status dp_status;

    // Sequencing of the divide, skip and row phases.
    tcs_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    // Arithmetic and row state.
    tcs_datapath #(
        .VIEW_ROWS (VIEW_ROWS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_column      (i_column),
        .i_light_bits  (i_light_bits),
        .i_dark_bits   (i_dark_bits),
        .i_distance    (i_distance),
        .i_dist_scale  (i_dist_scale),
        .o_pixel_pair  (o_pixel_pair),
        .o_row         (o_row),
        .o_light_pixel (o_light_pixel),
        .o_dark_pixel  (o_dark_pixel),
        .o_last        (o_last)
    );

endmodule

FILE: hdl/tcs_datapath.sv
// Datapath of the texture column scaler: height divider, texture walk and row counters.
`timescale 1ns / 1ps

module tcs_datapath #(
    parameter int VIEW_ROWS = tcs_pkg::VIEW_ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tcs_pkg::t_dp_cmd              i_cmd,
    output tcs_pkg::t_dp_status           o_status,
    input  logic [tcs_pkg::COLUMN_W-1:0]  i_column,
    input  logic [tcs_pkg::TEX_W-1:0]     i_light_bits,
    input  logic [tcs_pkg::TEX_W-1:0]     i_dark_bits,
    input  logic [tcs_pkg::DIST_W-1:0]    i_distance,
    input  logic [tcs_pkg::DIST_W-1:0]    i_dist_scale,
    output logic [tcs_pkg::PAIR_W-1:0]    o_pixel_pair,
    output logic [tcs_pkg::ROW_W-1:0]     o_row,
    output logic                          o_light_pixel,
    output logic                          o_dark_pixel,
    output logic                          o_last
);

    localparam int CNT_W  = $clog2(VIEW_ROWS + 1);
    localparam int RCNT_W = (CNT_W > tcs_pkg::ROW_W) ? CNT_W : tcs_pkg::ROW_W;

    // Slice registers.
    logic [tcs_pkg::PAIR_W-1:0]    r_pair;
    logic [tcs_pkg::TEX_W-1:0]     r_light, r_dark;
    logic [tcs_pkg::SCALED_W-1:0]  r_scaled;
    logic [tcs_pkg::DIVISOR_W-1:0] r_rem;
    logic [tcs_pkg::H_W-1:0]       r_quo;
    logic [tcs_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [tcs_pkg::H_W-1:0]       r_h;
    logic [tcs_pkg::ACC_W-1:0]     r_acc;
    logic [tcs_pkg::TEX_W-1:0]     r_pos;
    logic [tcs_pkg::SKIP_K_W-1:0]  r_skip_k;
    logic [RCNT_W-1:0]             r_row;
    logic [CNT_W-1:0]              r_left;

    logic [tcs_pkg::DIST_W-1:0]    product;
    logic [tcs_pkg::DIST_W-1:0]    divisor;
    logic [tcs_pkg::DIST_W-1:0]    rem_sh;
    logic                          rem_ge;
    logic [tcs_pkg::H_W-1:0]       h_calc;
    logic [tcs_pkg::ACC_W-1:0]     skip_cmp;
    logic [2:0]                    skip_sh;
    logic [tcs_pkg::ACC_W-1:0]     acc_step;

    // Low 16 bits of distance times scale, as on a 16-bit target.
    assign product = i_distance * i_dist_scale;

    // Restoring division of all-ones by 24 * scaled, one quotient bit a cycle.
    assign divisor = tcs_pkg::DIST_W'({r_scaled, 4'b0000})
                   + tcs_pkg::DIST_W'({r_scaled, 3'b000});
    assign rem_sh  = {r_rem, 1'b1};
    assign rem_ge  = (rem_sh >= divisor);

    // Height with the zero-distance override.
    assign h_calc = (r_scaled == '0) ? tcs_pkg::HEIGHT_AT_ZERO : r_quo;

    // Skip step compares against height shifted by 2, 1, then 0.
    assign skip_cmp = tcs_pkg::ACC_W'(r_h) << r_skip_k;
    assign skip_sh  = 3'b001 << r_skip_k;
    assign acc_step = r_acc + tcs_pkg::TEX_STEP;

    // Registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pair    <= i_column[tcs_pkg::COLUMN_W-1:1];
            r_light   <= i_light_bits;
            r_dark    <= i_dark_bits;
            r_scaled  <= product[tcs_pkg::DIST_W-1:tcs_pkg::SCALED_LSB];
            r_rem     <= '0;
            r_quo     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + 1'b1;
            r_quo     <= {r_quo[tcs_pkg::H_W-2:0], rem_ge};
            if (rem_ge) begin
                r_rem <= tcs_pkg::DIVISOR_W'(rem_sh - divisor);
            end else begin
                r_rem <= tcs_pkg::DIVISOR_W'(rem_sh);
            end
        end
        if (i_cmd.setup) begin
            r_h      <= h_calc;
            r_pos    <= tcs_pkg::TEX_TOP;
            r_skip_k <= tcs_pkg::SKIP_K_W'(tcs_pkg::SKIP_STEPS - 1);
            if (h_calc > tcs_pkg::H_W'(VIEW_ROWS)) begin
                // Clipped: start at row 0 and preload the accumulator with 8 * (h - rows).
                r_acc  <= tcs_pkg::ACC_W'({h_calc - tcs_pkg::H_W'(VIEW_ROWS), 3'b000});
                r_row  <= '0;
                r_left <= CNT_W'(VIEW_ROWS);
            end else begin
                // Centered: rows fit, so height fits the row counter.
                r_acc  <= '0;
                r_row  <= RCNT_W'((CNT_W'(VIEW_ROWS) - h_calc[CNT_W-1:0]) >> 1);
                r_left <= h_calc[CNT_W-1:0];
            end
        end
        if (i_cmd.skip_step) begin
            r_skip_k <= r_skip_k - 1'b1;
            if (r_acc >= skip_cmp) begin
                r_acc <= r_acc - skip_cmp;
                r_pos <= r_pos >> skip_sh;
            end
        end
        if (i_cmd.row_adv) begin
            r_acc  <= acc_step;
            r_row  <= r_row + 1'b1;
            r_left <= r_left - 1'b1;
        end
        if (i_cmd.sub) begin
            r_acc <= r_acc - tcs_pkg::ACC_W'(r_h);
            r_pos <= r_pos >> 1;
        end
    end

    // Status for the controller.
    always_comb begin
        o_status.div_last  = (r_div_cnt == tcs_pkg::DIV_CNT_W'(tcs_pkg::DIV_STEPS - 1));
        o_status.h_zero    = (h_calc == '0);
        o_status.clip      = (h_calc > tcs_pkg::H_W'(VIEW_ROWS));
        o_status.skip_last = (r_skip_k == '0);
        o_status.last_row  = (r_left == CNT_W'(1));
        o_status.acc_ge_h  = (r_acc >= tcs_pkg::ACC_W'(r_h));
    end

    // Row result fields.
    assign o_pixel_pair  = r_pair;
    assign o_row         = r_row[tcs_pkg::ROW_W-1:0];
    assign o_light_pixel = |(r_light & r_pos);
    assign o_dark_pixel  = |(r_dark & r_pos);
    assign o_last        = (r_left == CNT_W'(1));

    // Each delivered row takes exactly one off the remaining count.
    a_left_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.row_adv |=> r_left == CNT_W'($past(r_left) - 1'b1))
        else $error("row count did not step by one");

    // The texel pointer is one-hot or has run off the bottom.
    a_pos_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.row_adv || i_cmd.sub || i_cmd.skip_step) |=> $onehot0(r_pos))
        else $error("texel pointer lost its one-hot form");

endmodule

FILE: hdl/tcs_controller.sv
// Controller state machine of the texture column scaler.
`timescale 1ns / 1ps

module tcs_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  tcs_pkg::t_dp_status  i_status,
    output tcs_pkg::t_dp_cmd     o_cmd
);

    tcs_pkg::t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            tcs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tcs_pkg::ST_DIV;
                end
            end
            tcs_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = tcs_pkg::ST_SETUP;
                end
            end
            tcs_pkg::ST_SETUP: begin
                o_cmd.setup = 1'b1;
                if (i_status.h_zero) begin
                    n_state = tcs_pkg::ST_IDLE;
                end else if (i_status.clip) begin
                    n_state = tcs_pkg::ST_SKIP;
                end else begin
                    n_state = tcs_pkg::ST_EMIT;
                end
            end
            tcs_pkg::ST_SKIP: begin
                o_cmd.skip_step = 1'b1;
                if (i_status.skip_last) begin
                    n_state = tcs_pkg::ST_EMIT;
                end
            end
            tcs_pkg::ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.row_adv = 1'b1;
                    if (i_status.last_row) begin
                        n_state = tcs_pkg::ST_IDLE;
                    end else begin
                        n_state = tcs_pkg::ST_STEP;
                    end
                end
            end
            tcs_pkg::ST_STEP: begin
                // Move the texel pointer down once per height the accumulator holds.
                if (i_status.acc_ge_h) begin
                    o_cmd.sub = 1'b1;
                end else begin
                    n_state = tcs_pkg::ST_EMIT;
                end
            end
            default: begin
                n_state = tcs_pkg::ST_IDLE;
            end
        endcase
    end

    // A new request is never taken while a row is on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a row is pending");

    // An accepted request always starts the height division.
    a_load_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state == tcs_pkg::ST_DIV)
        else $error("accepted request did not start the divider");

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for the texture column scaler core.
`timescale 1ns / 1ps

module tb_top;

    localparam int VIEW_ROWS    = tcs_pkg::VIEW_ROWS_DEF;
    localparam int COLUMN_W     = tcs_pkg::COLUMN_W;
    localparam int TEX_W        = tcs_pkg::TEX_W;
    localparam int DIST_W       = tcs_pkg::DIST_W;
    localparam int PAIR_W       = tcs_pkg::PAIR_W;
    localparam int ROW_W        = tcs_pkg::ROW_W;
    localparam int SCALED_LSB   = tcs_pkg::SCALED_LSB;
    localparam int N_DIRECTED   = 22;
    localparam int N_RANDOM     = 240;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 600;
    localparam int HOLD_AFTER   = 400;
    localparam int MAX_REPORTS  = 40;

    // One wall slice request.
    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic [TEX_W-1:0]    light;
        logic [TEX_W-1:0]    dark;
        logic [DIST_W-1:0]   distance;
        logic [DIST_W-1:0]   dist_scale;
    } t_slice;

    // One drawn row.
    typedef struct packed {
        logic [PAIR_W-1:0] pair;
        logic [ROW_W-1:0]  row;
        logic              light_px;
        logic              dark_px;
        logic              last;
    } t_row;

    // Directed entry; typed entries carry the row count and first row by hand.
    typedef struct packed {
        logic       typed;
        logic [5:0] n_rows;
        logic [5:0] top_row;
        t_slice     s;
    } t_wall_case;

    // Receiver stall patterns.
    typedef enum logic [1:0] {
        RX_STREAM,
        RX_RANDOM,
        RX_SPARSE,
        RX_MOSTLY
    } t_rx_mode;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_ready;
    logic [COLUMN_W-1:0] i_column     = '0;
    logic [TEX_W-1:0]    i_light_bits = '0;
    logic [TEX_W-1:0]    i_dark_bits  = '0;
    logic [DIST_W-1:0]   i_distance   = '0;
    logic [DIST_W-1:0]   i_dist_scale = '0;
    logic                o_out_valid;
    logic                i_out_ready  = 1'b0;
    logic [PAIR_W-1:0]   o_pixel_pair;
    logic [ROW_W-1:0]    o_row;
    logic                o_light_pixel;
    logic                o_dark_pixel;
    logic                o_last;

    t_row       expected_rows[$];
    t_wall_case wall_cases[N_DIRECTED];
    int         mismatches = 0;
    int         burst_left = 0;
    int         idle_cycles = 0;

    texture_column_scaler_core #(
        .VIEW_ROWS(VIEW_ROWS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_column     (i_column),
        .i_light_bits (i_light_bits),
        .i_dark_bits  (i_dark_bits),
        .i_distance   (i_distance),
        .i_dist_scale (i_dist_scale),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_pair (o_pixel_pair),
        .o_row        (o_row),
        .o_light_pixel(o_light_pixel),
        .o_dark_pixel (o_dark_pixel),
        .o_last       (o_last)
    );

    // Free-running clock, 2 ns period.
    always #1 i_clk = ~i_clk;

    // Wall height from the wrapped 16-bit product of distance and factor.
    function automatic int unsigned wall_height(input logic [DIST_W-1:0] distance,
                                                input logic [DIST_W-1:0] dist_scale);
        logic [31:0] product;
        int unsigned scaled;
        product = 32'(distance) * 32'(dist_scale);
        scaled  = 32'(product[15:SCALED_LSB]);
        if (scaled == 0)
            return 32'(tcs_pkg::HEIGHT_AT_ZERO);
        return ((32'd65535 / scaled) >> 3) / 32'd3;
    endfunction

    // Work out every visible row of a slice and queue it.
    function automatic void scale_slice(input t_slice s);
        int unsigned h, tex_ptr, acc, top, count, skip, whole, i;
        t_row r;
        h       = wall_height(s.distance, s.dist_scale);
        tex_ptr = 32'(tcs_pkg::TEX_TOP);
        acc     = 0;
        if (h == 0)
            return;
        if (h > VIEW_ROWS) begin
            // Clipped: start the texture walk where the first visible row lands.
            skip    = 8 * h - 8 * VIEW_ROWS;
            whole   = skip / h;
            tex_ptr = tex_ptr >> whole;
            acc     = skip - whole * h;
            top     = 0;
            count   = VIEW_ROWS;
        end else begin
            top   = (VIEW_ROWS - h) / 2;
            count = h;
        end
        for (i = 0; i < count; i++) begin
            r.pair     = s.column[COLUMN_W-1:1];
            r.row      = ROW_W'(top + i);
            r.light_px = ((32'(s.light) & tex_ptr) != 0);
            r.dark_px  = ((32'(s.dark) & tex_ptr) != 0);
            r.last     = (i + 1 == count);
            expected_rows.push_back(r);
            acc += 32'(tcs_pkg::TEX_STEP);
            while (acc >= h) begin
                acc -= h;
                tex_ptr = tex_ptr >> 1;
            end
        end
    endfunction

    // Hand-typed slice: flat textures, so every row carries the same texel values.
    function automatic void queue_flat_slice(input t_slice s, input int unsigned n_rows,
                                             input int unsigned top_row);
        int unsigned i;
        t_row r;
        for (i = 0; i < n_rows; i++) begin
            r.pair     = s.column[COLUMN_W-1:1];
            r.row      = ROW_W'(top_row + i);
            r.light_px = s.light[0];
            r.dark_px  = s.dark[0];
            r.last     = (i + 1 == n_rows);
            expected_rows.push_back(r);
        end
    endfunction

    // Random slice, mostly with a chosen scaled distance split into two factors.
    function automatic t_slice random_slice();
        t_slice s;
        logic [15:0] product, odd_f, inv, tmp;
        logic [9:0] scaled;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if ($urandom_range(0, 7) == 0)
            s.column = COLUMN_W'($urandom_range(160, 255));
        else
            s.column = COLUMN_W'($urandom_range(0, 159));
        s.light = TEX_W'($urandom);
        s.dark  = TEX_W'($urandom);
        if (pick < 2) begin
            s.distance   = DIST_W'($urandom);
            s.dist_scale = DIST_W'($urandom);
        end else if (pick == 2) begin
            // Powers of two, so the product often wraps to zero.
            s.distance   = DIST_W'(1 << $urandom_range(0, 15));
            s.dist_scale = DIST_W'(1 << $urandom_range(0, 15));
            if ($urandom_range(0, 3) == 0)
                s.dist_scale = '0;
        end else begin
            case ($urandom_range(0, 2))
                0: scaled = 10'($urandom_range(0, 60));
                1: scaled = 10'($urandom_range(40, 300));
                default: scaled = 10'($urandom_range(0, 1023));
            endcase
            product = {scaled, 6'($urandom)};
            // An odd factor has an inverse modulo 2^16; Newton steps find it.
            odd_f = 16'($urandom) | 16'd1;
            inv   = odd_f;
            repeat (4) inv = inv * (16'd2 - odd_f * inv);
            s.distance   = product * inv;
            s.dist_scale = odd_f;
            if ($urandom_range(0, 1) == 1) begin
                tmp          = s.distance;
                s.distance   = s.dist_scale;
                s.dist_scale = tmp;
            end
        end
        return s;
    endfunction

    // Offer one request, wait for it to be taken, then maybe pause.
    task automatic offer(input t_slice s, input logic typed, input int unsigned n_rows,
                         input int unsigned top_row);
        int gap;
        i_in_valid   <= 1'b1;
        i_column     <= s.column;
        i_light_bits <= s.light;
        i_dark_bits  <= s.dark;
        i_distance   <= s.distance;
        i_dist_scale <= s.dist_scale;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        if (typed)
            queue_flat_slice(s, n_rows, top_row);
        else
            scale_slice(s);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    // Report one field mismatch.
    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Compare each delivered row with the oldest expected one.
    always @(posedge i_clk) begin
        t_row want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_rows.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected row, expected none, actual pair=%0d row=%0d",
                             $time, o_pixel_pair, o_row);
            end else begin
                want = expected_rows.pop_front();
                check_field("pixel_pair", int'(want.pair), int'(o_pixel_pair));
                check_field("row", int'(want.row), int'(o_row));
                check_field("light_pixel", int'(want.light_px), int'(o_light_pixel));
                check_field("dark_pixel", int'(want.dark_px), int'(o_dark_pixel));
                check_field("last", int'(want.last), int'(o_last));
            end
        end
    end

    // Receiver: changing stall patterns plus one long hold-off.
    t_rx_mode rx_mode   = RX_STREAM;
    int       mode_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       rows_seen = 0;
    int       rx_phase  = 0;

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready)
            rows_seen++;
        rx_phase++;
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && rows_seen >= HOLD_AFTER) begin
            // Stop taking rows long enough for the input side to back up.
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 256);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_STREAM: i_out_ready <= 1'b1;
                RX_RANDOM: i_out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: i_out_ready <= (rx_phase % 4 == 0);
                default:   i_out_ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no request or row taken for %0d cycles", $time, IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus: directed slices, then random ones, then drain and report.
    initial begin
        int i;
        wall_cases = '{
            // Zero and smallest scaled distance: clipped to the full screen.
            '{1'b1, 6'd50, 6'd0,  '{8'd0,   16'hFFFF, 16'h0000, 16'd0,     16'd0}},
            '{1'b1, 6'd50, 6'd0,  '{8'd159, 16'h0000, 16'hFFFF, 16'd1,     16'd64}},
            // Largest scaled distance gives the shortest slice.
            '{1'b1, 6'd2,  6'd24, '{8'd255, 16'hFFFF, 16'hFFFF, 16'hFFC0,  16'd1}},
            // Exactly screen height, then one row over it.
            '{1'b1, 6'd50, 6'd0,  '{8'd1,   16'h0000, 16'h0000, 16'd3456,  16'd1}},
            '{1'b1, 6'd50, 6'd0,  '{8'd2,   16'hFFFF, 16'hFFFF, 16'd3392,  16'd1}},
            // Full-scale operands wrap the product to one.
            '{1'b1, 6'd50, 6'd0,  '{8'd128, 16'hFFFF, 16'h0000, 16'hFFFF,  16'hFFFF}},
            // Product wraps to exactly zero; then short slices that fit on the screen.
            '{1'b1, 6'd50, 6'd0,  '{8'd64,  16'h0000, 16'hFFFF, 16'd256,   16'd256}},
            '{1'b1, 6'd3,  6'd23, '{8'd100, 16'hFFFF, 16'h0000, 16'd51200, 16'd1}},
            '{1'b1, 6'd10, 6'd20, '{8'd37,  16'h0000, 16'hFFFF, 16'd256,   16'd64}},
            '{1'b1, 6'd2,  6'd24, '{8'd254, 16'hFFFF, 16'h0000, 16'd1,     16'hFFFF}},
            // Textured slices checked against the predictor.
            '{1'b0, 6'd0,  6'd0,  '{8'd10,  16'hAAAA, 16'h5555, 16'd0,     16'd64}},
            '{1'b0, 6'd0,  6'd0,  '{8'd11,  16'h8000, 16'h0001, 16'd3456,  16'd1}},
            '{1'b0, 6'd0,  6'd0,  '{8'd12,  16'h0001, 16'h8000, 16'd3392,  16'd1}},
            '{1'b0, 6'd0,  6'd0,  '{8'd13,  16'h5555, 16'hAAAA, 16'd256,   16'd64}},
            '{1'b0, 6'd0,  6'd0,  '{8'd200, 16'h1234, 16'hFEDC, 16'd1000,  16'd100}},
            '{1'b0, 6'd0,  6'd0,  '{8'd77,  16'hF0F0, 16'h0F0F, 16'd64,    16'd64}},
            '{1'b0, 6'd0,  6'd0,  '{8'd159, 16'h00FF, 16'hFF00, 16'd30,    16'd64}},
            '{1'b0, 6'd0,  6'd0,  '{8'd3,   16'hC3C3, 16'h3C3C, 16'd2,     16'd64}},
            '{1'b0, 6'd0,  6'd0,  '{8'd90,  16'h8001, 16'h7FFE, 16'h8000,  16'd2}},
            '{1'b0, 6'd0,  6'd0,  '{8'd45,  16'h0180, 16'h0100, 16'd1,     16'd64}},
            '{1'b0, 6'd0,  6'd0,  '{8'd128, 16'hFFFE, 16'h7FFF, 16'hFFFF,  16'd3}},
            '{1'b0, 6'd0,  6'd0,  '{8'd255, 16'h8080, 16'h0808, 16'd2560,  16'd1}}
        };

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < N_DIRECTED; i++)
            offer(wall_cases[i].s, wall_cases[i].typed, 32'(wall_cases[i].n_rows),
                  32'(wall_cases[i].top_row));
        for (i = 0; i < N_RANDOM; i++)
            offer(random_slice(), 1'b0, 0, 0);
        i_in_valid <= 1'b0;

        while (expected_rows.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
